// File: rtl/core/mtep_pkg.sv
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types and constants for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

  // parse position within a track
  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_TEMPO     = 4'd6,
    PH_SYS_LEN   = 4'd7,
    PH_SKIP      = 4'd8
  } phase_e;

  // emitted event codes
  typedef enum logic [1:0] {
    EV_NOTE_ON  = 2'd0,
    EV_NOTE_OFF = 2'd1,
    EV_PROGRAM  = 2'd2,
    EV_TEMPO    = 2'd3
  } event_kind_e;

  // status and meta codes
  localparam logic [7:0] STATUS_MIN      = 8'h80;
  localparam logic [3:0] HI_NOTE_OFF     = 4'h8;
  localparam logic [3:0] HI_NOTE_ON      = 4'h9;
  localparam logic [3:0] HI_PROGRAM      = 4'hc;
  localparam logic [3:0] HI_CHAN_PRESS   = 4'hd;
  localparam logic [3:0] HI_SYSTEM       = 4'hf;
  localparam logic [7:0] STATUS_META     = 8'hff;
  localparam logic [7:0] META_SET_TEMPO  = 8'h51;
  localparam logic [1:0] TEMPO_BYTES     = 2'd3;
  localparam logic [15:0] LIMIT_RESET    = 16'd60000;

  // one input beat
  typedef struct packed {
    logic [7:0] track_byte;
    logic       last_in_track;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    event_kind_e kind;
    logic [31:0] tick;
    logic [3:0]  channel;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [7:0]  program_number;
    logic [23:0] tempo_us;
  } event_t;

endpackage

// File: rtl/core/midi_track_event_parser_top.sv
// ----------------------------------------------------------------------------
// midi_track_event_parser_top
// Parses track chunk bytes into note, program change and tempo events.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in       sink       in_valid/in_stall   track_byte, last_in_track
//  out      source     out_valid/out_stall event_kind .. tempo_us
//  cfg      sink       cfg_valid/cfg_ready cfg_event_limit
//
//  one byte beat per cycle while in_stall is low; each byte is decoded
//  combinationally between the input register and the result register
//  reset clears parse state, event count and sets the limit to 60000
//  a stalled result stalls the input only while the input register is full
//  config writes are always ready
// ----------------------------------------------------------------------------
module midi_track_event_parser_top #(
  parameter int unsigned TICK_BITS   = 32,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  track_byte_i,
  input  logic        last_in_track_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  event_kind_o,
  output logic [31:0] event_tick_o,
  output logic [3:0]  channel_o,
  output logic [7:0]  note_number_o,
  output logic [7:0]  velocity_o,
  output logic [7:0]  program_number_o,
  output logic [23:0] tempo_us_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_event_limit_i
);
  import mtep_pkg::*;

  in_beat_t    in_beat;
  in_beat_t    held_beat;
  logic        held_valid;
  logic        out_ready;
  logic        fire;
  logic        ev_valid;
  event_t      ev;
  event_t      out_ev;
  logic [15:0] limit_q;

  // event limit register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_event_limit_i;
    end
  end

  // input register
  assign in_beat.track_byte    = track_byte_i;
  assign in_beat.last_in_track = last_in_track_i;

  mtep_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (in_beat),
    .take_i     (out_ready),
    .valid_o    (held_valid),
    .beat_o     (held_beat)
  );

  // parse one held byte when the result side has room
  assign fire = held_valid && out_ready;

  mtep_parser #(
    .TICK_BITS   (TICK_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .beat_i        (held_beat),
    .event_limit_i (limit_q),
    .ev_valid_o    (ev_valid),
    .ev_o          (ev)
  );

  // result register
  mtep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && ev_valid),
    .ev_i        (ev),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ev_o        (out_ev)
  );

  assign event_kind_o     = out_ev.kind;
  assign event_tick_o     = out_ev.tick;
  assign channel_o        = out_ev.channel;
  assign note_number_o    = out_ev.note_number;
  assign velocity_o       = out_ev.velocity;
  assign program_number_o = out_ev.program_number;
  assign tempo_us_o       = out_ev.tempo_us;

endmodule

// File: rtl/core/mtep_in_reg.sv
// ----------------------------------------------------------------------------
// mtep_in_reg
// Input register: holds one byte beat until the parser consumes it.
// ----------------------------------------------------------------------------
module mtep_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mtep_pkg::in_beat_t beat_i,
  input  logic              take_i,
  output logic              valid_o,
  output mtep_pkg::in_beat_t beat_o
);
  import mtep_pkg::*;

  logic     valid_q;
  in_beat_t beat_q;
  logic     load;

  // stall only while a held beat cannot move on this cycle
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// File: rtl/core/mtep_parser.sv
// ----------------------------------------------------------------------------
// mtep_parser
// Track parse state and single-pass decode of one byte into at most one event.
// ----------------------------------------------------------------------------
module mtep_parser #(
  parameter int unsigned TICK_BITS   = 32,
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  mtep_pkg::in_beat_t beat_i,
  input  logic [15:0]        event_limit_i,
  output logic               ev_valid_o,
  output mtep_pkg::event_t   ev_o
);
  import mtep_pkg::*;

  localparam int unsigned SUM_BITS = (TICK_BITS > LENGTH_BITS) ? TICK_BITS : LENGTH_BITS;

  phase_e                 phase_q, phase_d;
  logic [7:0]             run_q, run_d;
  logic [7:0]             cur_q, cur_d;
  logic [TICK_BITS-1:0]   tick_q, tick_d;
  logic [LENGTH_BITS-1:0] var_q, var_d;
  logic [7:0]             first_q, first_d;
  logic [7:0]             meta_q, meta_d;
  logic [LENGTH_BITS-1:0] skip_q, skip_d;
  logic [23:0]            tempo_q, tempo_d;
  logic [1:0]             seen_q, seen_d;
  logic [15:0]            count_q, count_d;

  // entry phase for a status byte
  function automatic phase_e entry_phase(input logic [7:0] status);
    phase_e ph;
    if (status[7:4] >= HI_NOTE_OFF && status[7:4] < HI_SYSTEM) begin
      ph = PH_DATA1;
    end else if (status == STATUS_META) begin
      ph = PH_META_TYPE;
    end else begin
      ph = PH_SYS_LEN;
    end
    return ph;
  endfunction

  // decode one byte
  always_comb begin
    logic [7:0]             b;
    logic [3:0]             hi;
    logic [3:0]             ch;
    logic [LENGTH_BITS-1:0] acc;
    logic                   acc_done;
    logic                   want;
    logic [SUM_BITS-1:0]    sum;
    logic [LENGTH_BITS-1:0] skip_dec;
    logic [1:0]             seen_inc;
    logic [23:0]            tempo_sh;
    logic                   done;
    event_t                 ev;

    b        = beat_i.track_byte;
    phase_d  = phase_q;
    run_d    = run_q;
    cur_d    = cur_q;
    tick_d   = tick_q;
    var_d    = var_q;
    first_d  = first_q;
    meta_d   = meta_q;
    skip_d   = skip_q;
    tempo_d  = tempo_q;
    seen_d   = seen_q;
    count_d  = count_q;
    want     = 1'b0;
    done     = 1'b0;
    ev       = '0;
    ev.kind  = EV_NOTE_ON;

    // status position: a new status, or running status reused
    if (phase_q == PH_STATUS) begin
      if (b >= STATUS_MIN) begin
        cur_d   = b;
        run_d   = b;
        phase_d = entry_phase(b);
        done    = 1'b1;
      end else begin
        cur_d   = run_q;
        phase_d = entry_phase(run_q);
      end
      if (phase_d == PH_SYS_LEN) begin
        var_d = '0;
      end
    end

    hi       = cur_d[7:4];
    ch       = cur_d[3:0];
    acc      = {var_d[LENGTH_BITS-8:0], b[6:0]};
    acc_done = !b[7];
    sum      = SUM_BITS'(tick_q) + SUM_BITS'(acc);
    skip_dec = (skip_q != '0) ? skip_q - LENGTH_BITS'(1) : skip_q;
    seen_inc = seen_q + 2'd1;
    tempo_sh = {tempo_q[15:0], b};

    // per-phase byte handling
    if (!done) begin
      case (phase_d)
        PH_DATA1: begin
          first_d = b;
          if (hi == HI_PROGRAM) begin
            want              = 1'b1;
            ev.kind           = EV_PROGRAM;
            ev.channel        = ch;
            ev.program_number = b;
            phase_d           = PH_DELTA;
          end else if (hi == HI_CHAN_PRESS) begin
            phase_d = PH_DELTA;
          end else begin
            phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          ev.channel     = ch;
          ev.note_number = first_q;
          if (hi == HI_NOTE_OFF || (hi == HI_NOTE_ON && b == 8'd0)) begin
            want    = 1'b1;
            ev.kind = EV_NOTE_OFF;
          end else if (hi == HI_NOTE_ON) begin
            want        = 1'b1;
            ev.kind     = EV_NOTE_ON;
            ev.velocity = b;
          end
          phase_d = PH_DELTA;
        end
        PH_META_TYPE: begin
          meta_d  = b;
          var_d   = '0;
          phase_d = PH_META_LEN;
        end
        PH_META_LEN: begin
          var_d = acc;
          if (acc_done) begin
            skip_d  = acc;
            var_d   = '0;
            tempo_d = '0;
            seen_d  = '0;
            if (acc == '0) begin
              phase_d = PH_DELTA;
            end else if (meta_q == META_SET_TEMPO && acc == LENGTH_BITS'(3)) begin
              phase_d = PH_TEMPO;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          tempo_d = tempo_sh;
          seen_d  = seen_inc;
          if (seen_inc == TEMPO_BYTES) begin
            want        = 1'b1;
            ev.kind     = EV_TEMPO;
            ev.tempo_us = tempo_sh;
            skip_d      = '0;
            phase_d     = PH_DELTA;
          end
        end
        PH_SYS_LEN: begin
          var_d = acc;
          if (acc_done) begin
            skip_d  = acc;
            var_d   = '0;
            phase_d = (acc == '0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == '0) begin
            phase_d = PH_DELTA;
          end
        end
        default: begin
          var_d = acc;
          if (acc_done) begin
            tick_d  = TICK_BITS'(sum);
            var_d   = '0;
            phase_d = PH_STATUS;
          end
        end
      endcase
    end

    // event limit gate
    ev.tick    = 32'(tick_q);
    ev_valid_o = want && (count_q < event_limit_i);
    if (ev_valid_o) begin
      count_d = count_q + 16'd1;
    end
    ev_o = ev;

    // end of track clears the per-track state
    if (beat_i.last_in_track) begin
      phase_d = PH_DELTA;
      run_d   = '0;
      cur_d   = '0;
      tick_d  = '0;
      var_d   = '0;
      first_d = '0;
      meta_d  = '0;
      skip_d  = '0;
      tempo_d = '0;
      seen_d  = '0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      run_q   <= '0;
      cur_q   <= '0;
      tick_q  <= '0;
      var_q   <= '0;
      first_q <= '0;
      meta_q  <= '0;
      skip_q  <= '0;
      tempo_q <= '0;
      seen_q  <= '0;
      count_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      run_q   <= run_d;
      cur_q   <= cur_d;
      tick_q  <= tick_d;
      var_q   <= var_d;
      first_q <= first_d;
      meta_q  <= meta_d;
      skip_q  <= skip_d;
      tempo_q <= tempo_d;
      seen_q  <= seen_d;
      count_q <= count_d;
    end
  end

endmodule

// File: rtl/core/mtep_out_reg.sv
// ----------------------------------------------------------------------------
// mtep_out_reg
// Result register: holds one event beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module mtep_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  mtep_pkg::event_t ev_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mtep_pkg::event_t ev_o
);
  import mtep_pkg::*;

  logic   valid_q, valid_d;
  event_t ev_q;

  // free when empty or being drained this cycle
  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev_q <= ev_i;
    end
  end

  assign out_valid_o = valid_q;
  assign ev_o        = ev_q;

endmodule
